// ===== hdl/acns_pkg.sv =====
// Shared constants, types and helper functions for the aspect crop nearest scaler.
package acns_pkg;

   localparam int DIM_W     = 12;
   localparam int IDX_W     = 24;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int MAX_DIM   = 4096;
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 30;
   localparam int PROD_W    = 2 * DIM_W;
   localparam int DVD_W     = PROD_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(DVD_W);
   localparam int ORG_W     = DVD_W + 2;
   localparam int SUM_W     = POS_W + 2;
   localparam int RC_W      = (POS_W - FRAC_BITS + 1 > DIM_W + 1) ?
                              (POS_W - FRAC_BITS + 1) : (DIM_W + 1);
   localparam int HALF      = 1 << (FRAC_BITS - 1);
   localparam int POS_MAX   = (1 << (POS_W - 1)) - 1;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_RIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_BOTTOM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd7;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_CLAMPED = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd2;

   typedef struct packed {
      logic             clamped;
      logic [DIM_W-1:0] coord;
   } rc_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      if (32'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end
      return v;
   endfunction

   function automatic logic [DIM_W-1:0] nonzero_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end
      return v;
   endfunction

   // nearest integer, exact half rounds down, clamped to [0, lim - 1]
   function automatic rc_type round_clamp(input logic [POS_W-1:0] pos,
                                          input logic [DIM_W-1:0] lim);
      logic signed [RC_W-1:0] ip;
      logic signed [RC_W-1:0] top;
      rc_type r;
      ip = RC_W'($signed(pos[POS_W-1:FRAC_BITS]));
      if (pos[FRAC_BITS-1:0] > FRAC_BITS'(HALF)) begin
         ip = ip + RC_W'(1);
      end
      top = $signed(RC_W'(lim)) - RC_W'(1);
      r.clamped = 1'b0;
      r.coord   = ip[DIM_W-1:0];
      if (ip < 0) begin
         r.clamped = 1'b1;
         r.coord   = '0;
      end else if (ip > top) begin
         r.clamped = 1'b1;
         r.coord   = top[DIM_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [POS_W-1:0] sat_step(input logic [DVD_W-1:0] q);
      if (|q[DVD_W-1:POS_W]) begin
         return POS_W'(POS_MAX) | (POS_W'(1) << (POS_W - 1));
      end
      return q[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] pos,
                                                input logic [POS_W-1:0] step);
      logic signed [SUM_W-1:0] s;
      s = $signed({{2{pos[POS_W-1]}}, pos}) + $signed({2'b00, step});
      if (s > SUM_W'(POS_MAX)) begin
         return POS_W'(POS_MAX);
      end
      return s[POS_W-1:0];
   endfunction

   // floor(((lo + hi) << F) - extent) / 2), saturated to the position range
   function automatic logic [POS_W-1:0] origin_pos(input logic [DIM_W:0]   sum,
                                                   input logic [DVD_W-1:0] ext);
      logic signed [ORG_W-1:0] diff;
      logic signed [ORG_W-1:0] half_v;
      logic signed [ORG_W-1:0] hi;
      logic signed [ORG_W-1:0] lo;
      hi     = ORG_W'(POS_MAX);
      lo     = -hi - ORG_W'(1);
      diff   = $signed(ORG_W'(sum) << FRAC_BITS) - $signed(ORG_W'(ext));
      half_v = diff >>> 1;
      if (half_v > hi) begin
         return hi[POS_W-1:0];
      end else if (half_v < lo) begin
         return lo[POS_W-1:0];
      end
      return half_v[POS_W-1:0];
   endfunction

endpackage

// ===== hdl/aspect_crop_nearest_scaler.sv =====
// Centered aspect-preserving crop with nearest-neighbor source address generation.
// Plain transaction: states PIX0, PIX1 and PIX2 build the result, S_OUT loads the output register.
// Restart transaction with a nonzero target: extra setup states come first (two 12x12
//   products, then up to three restoring divisions on one shift-subtract unit).
// The next transaction is accepted once the result sits in the output register.
// Synchronous active-high reset: control and CSR registers only, no frame set up.
module aspect_crop_nearest_scaler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [acns_pkg::DIM_W-1:0]       rsp_src_col,
   output logic [acns_pkg::DIM_W-1:0]       rsp_src_row,
   output logic [acns_pkg::DIM_W-1:0]       rsp_dst_col,
   output logic [acns_pkg::DIM_W-1:0]       rsp_dst_row,
   output logic [acns_pkg::IDX_W-1:0]       rsp_src_index,
   output logic [acns_pkg::IDX_W-1:0]       rsp_dst_index,
   output logic [acns_pkg::STAT_W-1:0]      rsp_status,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [acns_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [acns_pkg::DIM_W-1:0]       csr_wdata
);

   localparam int DIM_W  = acns_pkg::DIM_W;
   localparam int IDX_W  = acns_pkg::IDX_W;
   localparam int STAT_W = acns_pkg::STAT_W;
   localparam int POS_W  = acns_pkg::POS_W;
   localparam int PROD_W = acns_pkg::PROD_W;
   localparam int DVD_W  = acns_pkg::DVD_W;
   localparam int CNT_W  = acns_pkg::CNT_W;
   localparam int FRAC   = acns_pkg::FRAC_BITS;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MUL_A   = 4'd1;
   localparam logic [3:0] S_MUL_B   = 4'd2;
   localparam logic [3:0] S_SEL     = 4'd3;
   localparam logic [3:0] S_DIV     = 4'd4;
   localparam logic [3:0] S_DIV_END = 4'd5;
   localparam logic [3:0] S_LDX     = 4'd6;
   localparam logic [3:0] S_LDY     = 4'd7;
   localparam logic [3:0] S_ORIG    = 4'd8;
   localparam logic [3:0] S_PIX0    = 4'd9;
   localparam logic [3:0] S_PIX1    = 4'd10;
   localparam logic [3:0] S_PIX2    = 4'd11;
   localparam logic [3:0] S_OUT     = 4'd12;

   localparam logic [1:0] PH_ASPECT = 2'd0;
   localparam logic [1:0] PH_X      = 2'd1;
   localparam logic [1:0] PH_Y      = 2'd2;

   // control
   logic [3:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              frame_ready_ff, frame_ready_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIM_W-1:0]  window_left_ff, window_left_in;
   logic [DIM_W-1:0]  window_top_ff, window_top_in;
   logic [DIM_W-1:0]  window_right_ff, window_right_in;
   logic [DIM_W-1:0]  window_bottom_ff, window_bottom_in;
   logic [DIM_W-1:0]  target_width_ff, target_width_in;
   logic [DIM_W-1:0]  target_height_ff, target_height_in;
   logic [DIM_W-1:0]  source_width_ff, source_width_in;
   logic [DIM_W-1:0]  source_height_ff, source_height_in;

   // datapath
   logic [PROD_W-1:0] prod_wth_ff, prod_wth_in;
   logic [PROD_W-1:0] prod_htw_ff, prod_htw_in;
   logic              wide_ff, wide_in;
   logic [DVD_W-1:0]  wf_ff, wf_in;
   logic [DVD_W-1:0]  hf_ff, hf_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DIM_W-1:0]  dvs_ff, dvs_in;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [POS_W-1:0]  pos_x_ff, pos_x_in;
   logic [POS_W-1:0]  pos_y_ff, pos_y_in;
   logic [POS_W-1:0]  origin_x_ff, origin_x_in;
   logic [POS_W-1:0]  step_x_ff, step_x_in;
   logic [POS_W-1:0]  step_y_ff, step_y_in;
   logic [DIM_W-1:0]  col_count_ff, col_count_in;
   logic [DIM_W-1:0]  row_count_ff, row_count_in;
   logic [DIM_W-1:0]  res_src_col_ff, res_src_col_in;
   logic [DIM_W-1:0]  res_src_row_ff, res_src_row_in;
   logic [DIM_W-1:0]  res_dst_col_ff, res_dst_col_in;
   logic [DIM_W-1:0]  res_dst_row_ff, res_dst_row_in;
   logic [IDX_W-1:0]  res_src_index_ff, res_src_index_in;
   logic [IDX_W-1:0]  res_dst_index_ff, res_dst_index_in;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic              res_last_ff, res_last_in;
   logic [DIM_W-1:0]  rsp_src_col_ff, rsp_src_col_in;
   logic [DIM_W-1:0]  rsp_src_row_ff, rsp_src_row_in;
   logic [DIM_W-1:0]  rsp_dst_col_ff, rsp_dst_col_in;
   logic [DIM_W-1:0]  rsp_dst_row_ff, rsp_dst_row_in;
   logic [IDX_W-1:0]  rsp_src_index_ff, rsp_src_index_in;
   logic [IDX_W-1:0]  rsp_dst_index_ff, rsp_dst_index_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic [DIM_W-1:0]  tw, th, sw, sh, win_w, win_h;
   logic [DIM_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [DIM_W+1:0]  div_diff;
   logic              div_ge;
   logic [DIM_W:0]    col_next, row_next;
   logic              col_end, is_last;
   acns_pkg::rc_type  rc_x, rc_y;

   assign tw    = acns_pkg::eff_dim(target_width_ff);
   assign th    = acns_pkg::eff_dim(target_height_ff);
   assign sw    = acns_pkg::nonzero_dim(acns_pkg::eff_dim(source_width_ff));
   assign sh    = acns_pkg::nonzero_dim(acns_pkg::eff_dim(source_height_ff));
   assign win_w = (window_right_ff > window_left_ff) ? window_right_ff - window_left_ff : '0;
   assign win_h = (window_bottom_ff > window_top_ff) ? window_bottom_ff - window_top_ff : '0;

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         S_MUL_A: begin
            mul_a = win_w;
            mul_b = th;
         end
         S_MUL_B: begin
            mul_a = win_h;
            mul_b = tw;
         end
         S_PIX1: begin
            mul_a = res_src_row_ff;
            mul_b = sw;
         end
         S_PIX2: begin
            mul_a = row_count_ff;
            mul_b = tw;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // shared restoring divider step
   assign div_diff = {1'b0, rem_ff, dvd_ff[DVD_W-1]} - {2'b00, dvs_ff};
   assign div_ge   = ~div_diff[DIM_W+1];

   assign col_next = {1'b0, col_count_ff} + 1'b1;
   assign row_next = {1'b0, row_count_ff} + 1'b1;
   assign col_end  = col_next >= {1'b0, tw};
   assign is_last  = col_end && (row_next >= {1'b0, th});
   assign rc_x     = acns_pkg::round_clamp(pos_x_ff, sw);
   assign rc_y     = acns_pkg::round_clamp(pos_y_ff, sh);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      cnt_in           = cnt_ff;
      frame_ready_in   = frame_ready_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      window_left_in   = window_left_ff;
      window_top_in    = window_top_ff;
      window_right_in  = window_right_ff;
      window_bottom_in = window_bottom_ff;
      target_width_in  = target_width_ff;
      target_height_in = target_height_ff;
      source_width_in  = source_width_ff;
      source_height_in = source_height_ff;
      prod_wth_in      = prod_wth_ff;
      prod_htw_in      = prod_htw_ff;
      wide_in          = wide_ff;
      wf_in            = wf_ff;
      hf_in            = hf_ff;
      dvd_in           = dvd_ff;
      dvs_in           = dvs_ff;
      rem_in           = rem_ff;
      pos_x_in         = pos_x_ff;
      pos_y_in         = pos_y_ff;
      origin_x_in      = origin_x_ff;
      step_x_in        = step_x_ff;
      step_y_in        = step_y_ff;
      col_count_in     = col_count_ff;
      row_count_in     = row_count_ff;
      res_src_col_in   = res_src_col_ff;
      res_src_row_in   = res_src_row_ff;
      res_dst_col_in   = res_dst_col_ff;
      res_dst_row_in   = res_dst_row_ff;
      res_src_index_in = res_src_index_ff;
      res_dst_index_in = res_dst_index_ff;
      res_status_in    = res_status_ff;
      res_last_in      = res_last_ff;
      rsp_src_col_in   = rsp_src_col_ff;
      rsp_src_row_in   = rsp_src_row_ff;
      rsp_dst_col_in   = rsp_dst_col_ff;
      rsp_dst_row_in   = rsp_dst_row_ff;
      rsp_src_index_in = rsp_src_index_ff;
      rsp_dst_index_in = rsp_dst_index_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            acns_pkg::REG_WINDOW_LEFT:   window_left_in   = csr_wdata;
            acns_pkg::REG_WINDOW_TOP:    window_top_in    = csr_wdata;
            acns_pkg::REG_WINDOW_RIGHT:  window_right_in  = csr_wdata;
            acns_pkg::REG_WINDOW_BOTTOM: window_bottom_in = csr_wdata;
            acns_pkg::REG_TARGET_WIDTH:  target_width_in  = csr_wdata;
            acns_pkg::REG_TARGET_HEIGHT: target_height_in = csr_wdata;
            acns_pkg::REG_SOURCE_WIDTH:  source_width_in  = csr_wdata;
            acns_pkg::REG_SOURCE_HEIGHT: source_height_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_restart && tw != '0 && th != '0) begin
                  state_in = S_MUL_A;
               end else begin
                  state_in = S_PIX0;
               end
            end
         end
         S_MUL_A: begin
            prod_wth_in = prod;
            state_in    = S_MUL_B;
         end
         S_MUL_B: begin
            prod_htw_in = prod;
            state_in    = S_SEL;
         end
         S_SEL: begin
            wide_in  = prod_wth_ff > prod_htw_ff;
            rem_in   = '0;
            cnt_in   = '0;
            phase_in = PH_ASPECT;
            if (prod_wth_ff > prod_htw_ff) begin
               wf_in  = DVD_W'(win_w) << FRAC;
               dvd_in = DVD_W'(prod_wth_ff) << FRAC;
               dvs_in = tw;
            end else begin
               hf_in  = DVD_W'(win_h) << FRAC;
               dvd_in = DVD_W'(prod_htw_ff) << FRAC;
               dvs_in = th;
            end
            state_in = S_DIV;
         end
         S_DIV: begin
            dvd_in = {dvd_ff[DVD_W-2:0], div_ge};
            rem_in = div_ge ? div_diff[DIM_W-1:0] : {rem_ff[DIM_W-2:0], dvd_ff[DVD_W-1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               state_in = S_DIV_END;
            end
         end
         S_DIV_END: begin
            unique case (phase_ff)
               PH_ASPECT: begin
                  if (wide_ff) begin
                     hf_in = dvd_ff;
                  end else begin
                     wf_in = dvd_ff;
                  end
                  state_in = S_LDX;
               end
               PH_X: begin
                  step_x_in = acns_pkg::sat_step(dvd_ff);
                  state_in  = S_LDY;
               end
               PH_Y: begin
                  step_y_in = acns_pkg::sat_step(dvd_ff);
                  state_in  = S_ORIG;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LDX: begin
            if (tw > DIM_W'(1)) begin
               dvd_in   = wf_ff;
               dvs_in   = tw - 1'b1;
               rem_in   = '0;
               cnt_in   = '0;
               phase_in = PH_X;
               state_in = S_DIV;
            end else begin
               step_x_in = '0;
               state_in  = S_LDY;
            end
         end
         S_LDY: begin
            if (th > DIM_W'(1)) begin
               dvd_in   = hf_ff;
               dvs_in   = th - 1'b1;
               rem_in   = '0;
               cnt_in   = '0;
               phase_in = PH_Y;
               state_in = S_DIV;
            end else begin
               step_y_in = '0;
               state_in  = S_ORIG;
            end
         end
         S_ORIG: begin
            origin_x_in    = acns_pkg::origin_pos({1'b0, window_left_ff}
                                                  + {1'b0, window_right_ff}, wf_ff);
            pos_x_in       = origin_x_in;
            pos_y_in       = acns_pkg::origin_pos({1'b0, window_top_ff}
                                                  + {1'b0, window_bottom_ff}, hf_ff);
            col_count_in   = '0;
            row_count_in   = '0;
            frame_ready_in = 1'b1;
            state_in       = S_PIX0;
         end
         S_PIX0: begin
            if (!frame_ready_ff || tw == '0 || th == '0) begin
               frame_ready_in   = 1'b0;
               res_src_col_in   = '0;
               res_src_row_in   = '0;
               res_dst_col_in   = '0;
               res_dst_row_in   = '0;
               res_src_index_in = '0;
               res_dst_index_in = '0;
               res_status_in    = acns_pkg::STATUS_EMPTY;
               res_last_in      = 1'b0;
               state_in         = S_OUT;
            end else begin
               res_src_col_in = rc_x.coord;
               res_src_row_in = rc_y.coord;
               res_status_in  = (rc_x.clamped || rc_y.clamped) ?
                                acns_pkg::STATUS_CLAMPED : acns_pkg::STATUS_OK;
               state_in       = S_PIX1;
            end
         end
         S_PIX1: begin
            res_src_index_in = IDX_W'(prod) + IDX_W'(res_src_col_ff);
            state_in         = S_PIX2;
         end
         S_PIX2: begin
            res_dst_index_in = IDX_W'(prod) + IDX_W'(col_count_ff);
            res_dst_col_in   = col_count_ff;
            res_dst_row_in   = row_count_ff;
            res_last_in      = is_last;
            if (is_last) begin
               frame_ready_in = 1'b0;
            end else if (col_end) begin
               col_count_in = '0;
               row_count_in = row_next[DIM_W-1:0];
               pos_x_in     = origin_x_ff;
               pos_y_in     = acns_pkg::sat_add(pos_y_ff, step_y_ff);
            end else begin
               col_count_in = col_next[DIM_W-1:0];
               pos_x_in     = acns_pkg::sat_add(pos_x_ff, step_x_ff);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_src_col_in   = res_src_col_ff;
               rsp_src_row_in   = res_src_row_ff;
               rsp_dst_col_in   = res_dst_col_ff;
               rsp_dst_row_in   = res_dst_row_ff;
               rsp_src_index_in = res_src_index_ff;
               rsp_dst_index_in = res_dst_index_ff;
               rsp_status_in    = res_status_ff;
               rsp_last_in      = res_last_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         phase_ff         <= PH_ASPECT;
         cnt_ff           <= '0;
         frame_ready_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         window_left_ff   <= '0;
         window_top_ff    <= '0;
         window_right_ff  <= '0;
         window_bottom_ff <= '0;
         target_width_ff  <= '0;
         target_height_ff <= '0;
         source_width_ff  <= DIM_W'(1);
         source_height_ff <= DIM_W'(1);
      end else begin
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         cnt_ff           <= cnt_in;
         frame_ready_ff   <= frame_ready_in;
         rsp_valid_ff     <= rsp_valid_in;
         window_left_ff   <= window_left_in;
         window_top_ff    <= window_top_in;
         window_right_ff  <= window_right_in;
         window_bottom_ff <= window_bottom_in;
         target_width_ff  <= target_width_in;
         target_height_ff <= target_height_in;
         source_width_ff  <= source_width_in;
         source_height_ff <= source_height_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_wth_ff      <= prod_wth_in;
      prod_htw_ff      <= prod_htw_in;
      wide_ff          <= wide_in;
      wf_ff            <= wf_in;
      hf_ff            <= hf_in;
      dvd_ff           <= dvd_in;
      dvs_ff           <= dvs_in;
      rem_ff           <= rem_in;
      pos_x_ff         <= pos_x_in;
      pos_y_ff         <= pos_y_in;
      origin_x_ff      <= origin_x_in;
      step_x_ff        <= step_x_in;
      step_y_ff        <= step_y_in;
      col_count_ff     <= col_count_in;
      row_count_ff     <= row_count_in;
      res_src_col_ff   <= res_src_col_in;
      res_src_row_ff   <= res_src_row_in;
      res_dst_col_ff   <= res_dst_col_in;
      res_dst_row_ff   <= res_dst_row_in;
      res_src_index_ff <= res_src_index_in;
      res_dst_index_ff <= res_dst_index_in;
      res_status_ff    <= res_status_in;
      res_last_ff      <= res_last_in;
      rsp_src_col_ff   <= rsp_src_col_in;
      rsp_src_row_ff   <= rsp_src_row_in;
      rsp_dst_col_ff   <= rsp_dst_col_in;
      rsp_dst_row_ff   <= rsp_dst_row_in;
      rsp_src_index_ff <= rsp_src_index_in;
      rsp_dst_index_ff <= rsp_dst_index_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_src_col   = rsp_src_col_ff;
   assign rsp_src_row   = rsp_src_row_ff;
   assign rsp_dst_col   = rsp_dst_col_ff;
   assign rsp_dst_row   = rsp_dst_row_ff;
   assign rsp_src_index = rsp_src_index_ff;
   assign rsp_dst_index = rsp_dst_index_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== sim/aspect_crop_nearest_scaler_test.sv =====
// Self-checking testbench for the crop scaler: directed cases, then random config phases against a predictor.
module aspect_crop_nearest_scaler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_W         = acns_pkg::DIM_W;
   localparam int IDX_W         = acns_pkg::IDX_W;
   localparam int STAT_W        = acns_pkg::STAT_W;
   localparam int CSR_IDX_W     = acns_pkg::CSR_IDX_W;
   localparam int MAX_DIM       = acns_pkg::MAX_DIM;
   localparam int FRAC_BITS     = acns_pkg::FRAC_BITS;
   localparam int ITEM_TARGET   = 825;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 140;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [DIM_W-1:0]  src_col;
      logic [DIM_W-1:0]  src_row;
      logic [DIM_W-1:0]  dst_col;
      logic [DIM_W-1:0]  dst_row;
      logic [IDX_W-1:0]  src_index;
      logic [IDX_W-1:0]  dst_index;
      logic [STAT_W-1:0] status;
      logic              last;
   } pixel_type;

   class scale_scoreboard;
      pixel_type        pending[$];
      logic [DIM_W-1:0] regs [8];
      longint           pos_x, pos_y, origin_x, step_x, step_y;
      longint           col_count, row_count;
      bit               frame_ready;
      int               errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         regs[acns_pkg::REG_SOURCE_WIDTH]  = DIM_W'(1);
         regs[acns_pkg::REG_SOURCE_HEIGHT] = DIM_W'(1);
         pos_x = 0; pos_y = 0; origin_x = 0;
         step_x = 0; step_y = 0;
         col_count = 0; row_count = 0;
         frame_ready = 0;
         errors = 0;
      endfunction

      function longint capped(logic [DIM_W-1:0] v);
         return (v > MAX_DIM) ? longint'(MAX_DIM) : longint'(v);
      endfunction

      function longint limit_pos(longint v);
         if (v > (longint'(1) <<< 29) - 1) return (longint'(1) <<< 29) - 1;
         if (v < -(longint'(1) <<< 29)) return -(longint'(1) <<< 29);
         return v;
      endfunction

      function longint limit_step(longint v);
         return (v > (longint'(1) <<< 30) - 1) ? (longint'(1) <<< 30) - 1 : v;
      endfunction

      // exact half goes down, anything above goes up; then clip into [0, lim - 1]
      function longint nearest(longint p, longint lim, inout bit clipped);
         longint ip;
         longint fr;
         ip = p >>> FRAC_BITS;
         fr = p & ((longint'(1) <<< FRAC_BITS) - 1);
         if (fr > (longint'(1) <<< (FRAC_BITS - 1))) ip++;
         if (ip < 0) begin
            clipped = 1;
            return 0;
         end
         if (ip > lim - 1) begin
            clipped = 1;
            return lim - 1;
         end
         return ip;
      endfunction

      function void start_frame(longint tw, longint th);
         longint l, t, r, b, w, h, wf, hf;
         l = regs[acns_pkg::REG_WINDOW_LEFT];
         t = regs[acns_pkg::REG_WINDOW_TOP];
         r = regs[acns_pkg::REG_WINDOW_RIGHT];
         b = regs[acns_pkg::REG_WINDOW_BOTTOM];
         w = (r > l) ? r - l : 0;
         h = (b > t) ? b - t : 0;
         if (w * th > h * tw) begin
            wf = w <<< FRAC_BITS;
            hf = ((w * th) <<< FRAC_BITS) / tw;
         end else begin
            hf = h <<< FRAC_BITS;
            wf = ((h * tw) <<< FRAC_BITS) / th;
         end
         origin_x = limit_pos((((l + r) <<< FRAC_BITS) - wf) >>> 1);
         pos_y    = limit_pos((((t + b) <<< FRAC_BITS) - hf) >>> 1);
         step_x   = (tw > 1) ? limit_step(wf / (tw - 1)) : 0;
         step_y   = (th > 1) ? limit_step(hf / (th - 1)) : 0;
         pos_x    = origin_x;
         col_count = 0;
         row_count = 0;
         frame_ready = 1;
      endfunction

      function void note_input(logic restart);
         longint    tw, th, sw, sh, sc, sr;
         bit        clipped;
         bit        fin;
         pixel_type px;
         tw = capped(regs[acns_pkg::REG_TARGET_WIDTH]);
         th = capped(regs[acns_pkg::REG_TARGET_HEIGHT]);
         sw = capped(regs[acns_pkg::REG_SOURCE_WIDTH]);
         sh = capped(regs[acns_pkg::REG_SOURCE_HEIGHT]);
         if (sw == 0) sw = 1;
         if (sh == 0) sh = 1;
         px = '0;
         if (restart && tw != 0 && th != 0) start_frame(tw, th);
         if (!frame_ready || tw == 0 || th == 0) begin
            frame_ready = 0;
            px.status = acns_pkg::STATUS_EMPTY;
            pending.push_back(px);
            return;
         end
         clipped = 0;
         sc  = nearest(pos_x, sw, clipped);
         sr  = nearest(pos_y, sh, clipped);
         fin = (col_count + 1 >= tw) && (row_count + 1 >= th);
         px.src_col   = DIM_W'(sc);
         px.src_row   = DIM_W'(sr);
         px.dst_col   = DIM_W'(col_count);
         px.dst_row   = DIM_W'(row_count);
         px.src_index = IDX_W'(sr * sw + sc);
         px.dst_index = IDX_W'(row_count * tw + col_count);
         px.status    = clipped ? acns_pkg::STATUS_CLAMPED : acns_pkg::STATUS_OK;
         px.last      = fin;
         pending.push_back(px);
         if (fin) begin
            frame_ready = 0;
         end else if (col_count + 1 >= tw) begin
            col_count = 0;
            row_count = (row_count + 1) & 'hFFF;
            pos_x = origin_x;
            pos_y = limit_pos(pos_y + step_y);
         end else begin
            col_count = (col_count + 1) & 'hFFF;
            pos_x = limit_pos(pos_x + step_x);
         end
      endfunction

      task report(string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      task compare(string name, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
         if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
      endtask

      task check_result(pixel_type got);
         pixel_type want;
         if (pending.size() == 0) begin
            report("result with no transaction outstanding");
            return;
         end
         want = pending.pop_front();
         compare("src_col", IDX_W'(got.src_col), IDX_W'(want.src_col));
         compare("src_row", IDX_W'(got.src_row), IDX_W'(want.src_row));
         compare("dst_col", IDX_W'(got.dst_col), IDX_W'(want.dst_col));
         compare("dst_row", IDX_W'(got.dst_row), IDX_W'(want.dst_row));
         compare("src_index", got.src_index, want.src_index);
         compare("dst_index", got.dst_index, want.dst_index);
         compare("status", IDX_W'(got.status), IDX_W'(want.status));
         compare("last", IDX_W'(got.last), IDX_W'(want.last));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DIM_W-1:0]     rsp_src_col;
   logic [DIM_W-1:0]     rsp_src_row;
   logic [DIM_W-1:0]     rsp_dst_col;
   logic [DIM_W-1:0]     rsp_dst_row;
   logic [IDX_W-1:0]     rsp_src_index;
   logic [IDX_W-1:0]     rsp_dst_index;
   logic [STAT_W-1:0]    rsp_status;
   logic                 rsp_last;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = acns_pkg::REG_WINDOW_LEFT;
   logic [DIM_W-1:0]     csr_wdata = '0;

   scale_scoreboard sb = new();
   pixel_type       seen;
   int              items_sent = 0;
   int              cycles = 0;
   bit              quiet = 1'b0;
   bit              hold_off_req = 1'b0;

   aspect_crop_nearest_scaler dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL aspect_crop_nearest_scaler");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_input(req_restart);
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_src_col, rsp_src_row, rsp_dst_col, rsp_dst_row,
                    rsp_src_index, rsp_dst_index, rsp_status, rsp_last};
            sb.check_result(seen);
         end
      end
   end

   // receiver: random backpressure, one long hold-off on request
   initial begin
      int stall;
      int pick;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               rsp_ready <= 1'b1;
            end else if (pick < 99) begin
               rsp_ready <= 1'b0;
               stall = $urandom_range(0, 2);
            end else begin
               rsp_ready <= 1'b0;
               stall = $urandom_range(20, 80);
            end
         end
      end
   end

   task automatic send_item(input logic restart);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 60) return;
      @(negedge clock);
      req_valid <= 1'b0;
      if (pick < 95) repeat ($urandom_range(0, 2)) @(negedge clock);
      else repeat ($urandom_range(19, 59)) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_one(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(val);
      sb.regs[idx] = DIM_W'(val);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_regs(input int unsigned l, t, r, b, tw, th, sw, sh);
      write_one(acns_pkg::REG_WINDOW_LEFT, l);
      write_one(acns_pkg::REG_WINDOW_TOP, t);
      write_one(acns_pkg::REG_WINDOW_RIGHT, r);
      write_one(acns_pkg::REG_WINDOW_BOTTOM, b);
      write_one(acns_pkg::REG_TARGET_WIDTH, tw);
      write_one(acns_pkg::REG_TARGET_HEIGHT, th);
      write_one(acns_pkg::REG_SOURCE_WIDTH, sw);
      write_one(acns_pkg::REG_SOURCE_HEIGHT, sh);
      end_writes();
   endtask

   task automatic random_phase(input int phase);
      int unsigned l, t, r, b, tw, th, sw, sh, pick, n;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         l = $urandom_range(0, 4000);
         t = $urandom_range(0, 4000);
         r = l + $urandom_range(0, 1000);
         b = t + $urandom_range(0, 1000);
         if (r > 4095) r = 4095;
         if (b > 4095) b = 4095;
      end else begin
         l = $urandom_range(0, 4095);
         t = $urandom_range(0, 4095);
         r = $urandom_range(0, 4095);
         b = $urandom_range(0, 4095);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         tw = 0;
         th = $urandom_range(0, 8);
      end else if (pick == 1) begin
         tw = $urandom_range(1, 8);
         th = 0;
      end else if (pick < 4) begin
         tw = $urandom_range(1, 4095);
         th = $urandom_range(1, 4095);
      end else begin
         tw = $urandom_range(1, 8);
         th = $urandom_range(1, 8);
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         sw = 0;
         sh = $urandom_range(0, 4095);
      end else if (pick < 5) begin
         sw = $urandom_range(1, 16);
         sh = $urandom_range(1, 16);
      end else if (pick == 5) begin
         sw = 4095;
         sh = 4095;
      end else begin
         sw = $urandom_range(1, 4095);
         sh = $urandom_range(1, 4095);
      end
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
         tw = 8;
         th = 8;
         quiet = 1'b1;
      end
      write_regs(l, t, r, b, tw, th, sw, sh);
      if (phase == 0) hold_off_req = 1'b1;
      if (phase != 0 && $urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(5, 15)) begin
            send_item(1'($urandom_range(0, 1)));
            sender_gap();
         end
      end else if (tw * th <= 64) begin
         repeat ($urandom_range(1, 3)) begin
            send_item(1'b1);
            sender_gap();
            for (n = 1; n < tw * th; n++) begin
               send_item($urandom_range(0, 29) == 0);
               sender_gap();
            end
         end
         repeat ($urandom_range(0, 2)) begin
            send_item(1'b0);
            sender_gap();
         end
      end else begin
         send_item(1'b1);
         sender_gap();
         repeat ($urandom_range(1, 20)) begin
            send_item($urandom_range(0, 19) == 0);
            sender_gap();
         end
      end
      drain();
   endtask

   initial begin
      int phase;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing set up yet, then restart with an empty target
      send_item(1'b0);
      send_item(1'b1);
      drain();

      // small full frame, one pixel past the end
      write_regs(10, 20, 50, 40, 3, 2, 64, 48);
      send_item(1'b1);
      repeat (6) send_item(1'b0);
      drain();

      // inverted window on both axes, zero source size, largest target
      write_regs(4095, 4095, 0, 0, 4095, 4095, 0, 0);
      send_item(1'b1);
      repeat (2) send_item(1'b0);
      drain();

      // full window, one-column target
      write_regs(0, 0, 4095, 4095, 1, 4095, 4095, 4095);
      send_item(1'b1);
      repeat (2) send_item(1'b0);
      drain();

      // target height drops to zero mid-frame, frame stays dead after restore
      write_one(acns_pkg::REG_TARGET_HEIGHT, 0);
      end_writes();
      send_item(1'b0);
      drain();
      write_one(acns_pkg::REG_TARGET_HEIGHT, 4095);
      end_writes();
      send_item(1'b0);
      drain();

      // width shrinks while a row is open
      write_regs(0, 0, 100, 100, 5, 4, 4095, 1);
      send_item(1'b1);
      repeat (3) send_item(1'b0);
      drain();
      write_one(acns_pkg::REG_TARGET_WIDTH, 2);
      end_writes();
      repeat (2) send_item(1'b0);
      drain();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         random_phase(phase);
         phase++;
      end

      quiet = 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending.size()));
      if (sb.errors == 0) begin
         $display("PASS aspect_crop_nearest_scaler");
      end else begin
         $display("FAIL aspect_crop_nearest_scaler");
      end
      $finish;
   end

endmodule
